// ===== hdl/mwa_pkg.sv =====
// shared constants for the moving window average block
// no dependencies; imported by mwa_front, mwa_back and the top level
`default_nettype none

package mwa_pkg;

    // accumulator width of the running sum
    localparam int SUM_BITS = 24;

    // window length register
    localparam int CFG_BITS = 9;
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 9'd32;

    // default build parameters
    localparam int MAX_WINDOW_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 16;

endpackage : mwa_pkg

`default_nettype wire

// ===== hdl/mwa_ram.sv =====
// generic simple dual port ram, one write port, one registered read port
// read returns the old contents on a same-address write; no dependencies
`default_nettype none

module mwa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // storage with read-first registered output
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule : mwa_ram

`default_nettype wire

// ===== hdl/mwa_front.sv =====
// front end: window length register, delay line, running sum and divisor choice
// depends on mwa_pkg and mwa_ram; feeds {sum, divisor} beats to the queue
`default_nettype none

module mwa_front
    import mwa_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [CFG_BITS-1:0]                   cfg_data,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic signed [SAMPLE_BITS-1:0]         sample,
    input  wire logic                                  start_of_record,
    output logic                                       q_push,
    input  wire logic                                  q_full,
    output logic [SUM_BITS+$clog2(MAX_WINDOW+1)-1:0]   q_data
);

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int CMP_W = (LEN_W > CFG_BITS) ? LEN_W : CFG_BITS;
    localparam int EXT_W = (SAMPLE_BITS > SUM_BITS) ? SAMPLE_BITS : SUM_BITS;

    logic [CFG_BITS-1:0]          window_length_reg;
    logic [PTR_W-1:0]             wp_reg, wp_next;
    logic [LEN_W-1:0]             fill_reg, fill_next;
    logic [SUM_BITS-1:0]          sum_reg, sum_next;
    logic                         b_valid_reg, b_valid_next;
    logic signed [SAMPLE_BITS-1:0] b_x_reg;
    logic                         b_start_reg;
    logic                         b_sub_reg;
    logic [LEN_W-1:0]             b_div_reg;

    logic                         accept;
    logic                         b_fire;
    logic [CMP_W-1:0]             cfg_ext;
    logic [LEN_W-1:0]             len;
    logic [LEN_W-1:0]             fill_eff;
    logic [LEN_W:0]               fill_inc;
    logic [LEN_W-1:0]             divisor;
    logic                         sub;
    logic [LEN_W:0]               idx_raw;
    logic [PTR_W-1:0]             rd_idx;
    logic [SAMPLE_BITS-1:0]       rd_data;
    logic signed [EXT_W-1:0]      x_wide;
    logic signed [EXT_W-1:0]      d_wide;
    logic [SUM_BITS-1:0]          base;
    logic [SUM_BITS-1:0]          sub_val;

    // handshake
    assign b_fire = b_valid_reg && !q_full;
    assign full   = b_valid_reg && q_full;
    assign accept = push && !full;

    // effective window length, clamped to 1..MAX_WINDOW
    assign cfg_ext = CMP_W'(window_length_reg);
    always_comb
    begin
        priority if (cfg_ext == '0)
        begin
            len = LEN_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_WINDOW))
        begin
            len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len = cfg_ext[LEN_W-1:0];
        end
    end

    // fill count, subtract decision and divisor for the accepted beat
    assign fill_eff = start_of_record ? '0 : fill_reg;
    assign fill_inc = (LEN_W+1)'(fill_eff) + (LEN_W+1)'(1);
    assign sub      = fill_eff >= len;
    assign divisor  = (fill_inc < (LEN_W+1)'(len)) ? fill_inc[LEN_W-1:0] : len;
    assign fill_next = (fill_eff < LEN_W'(MAX_WINDOW)) ? fill_inc[LEN_W-1:0] : fill_eff;

    // address of the sample leaving the window
    assign idx_raw = (LEN_W+1)'(wp_reg) + (LEN_W+1)'(MAX_WINDOW) - (LEN_W+1)'(len);
    always_comb
    begin
        if (idx_raw >= (LEN_W+1)'(MAX_WINDOW))
        begin
            rd_idx = PTR_W'(idx_raw - (LEN_W+1)'(MAX_WINDOW));
        end
        else
        begin
            rd_idx = idx_raw[PTR_W-1:0];
        end
    end

    assign wp_next = (wp_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_reg + PTR_W'(1);

    // delay line
    mwa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_delay (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wp_reg),
        .wr_data (sample),
        .rd_en   (accept),
        .rd_addr (rd_idx),
        .rd_data (rd_data)
    );

    // sum update stage, works on the beat registers and ram output loaded at accept
    assign x_wide   = EXT_W'(b_x_reg);
    assign d_wide   = EXT_W'($signed(rd_data));
    assign base     = b_start_reg ? '0 : sum_reg;
    assign sub_val  = b_sub_reg ? d_wide[SUM_BITS-1:0] : '0;
    assign sum_next = base + x_wide[SUM_BITS-1:0] - sub_val;

    assign q_push = b_fire;
    assign q_data = {sum_next, b_div_reg};

    always_comb
    begin
        if (accept)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_fire)
        begin
            b_valid_next = 1'b0;
        end
        else
        begin
            b_valid_next = b_valid_reg;
        end
    end

    // control and accumulator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_RESET;
            wp_reg            <= '0;
            fill_reg          <= '0;
            sum_reg           <= '0;
            b_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                window_length_reg <= cfg_data;
            end
            if (accept)
            begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
            end
            if (b_fire)
            begin
                sum_reg <= sum_next;
            end
            b_valid_reg <= b_valid_next;
        end
    end

    // beat payload held for the sum stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_x_reg     <= sample;
            b_start_reg <= start_of_record;
            b_sub_reg   <= sub;
            b_div_reg   <= divisor;
        end
    end

endmodule : mwa_front

`default_nettype wire

// ===== hdl/mwa_fifo.sv =====
// two entry register queue between front and back
// no dependencies beyond its width parameter
`default_nettype none

module mwa_fifo #(
    parameter int WIDTH = 33
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule : mwa_fifo

`default_nettype wire

// ===== hdl/mwa_back.sv =====
// back end: bit-serial signed division of the sum, saturation, output register
// depends on mwa_pkg; takes {sum, divisor} beats from the queue
`default_nettype none

module mwa_back
    import mwa_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  q_empty,
    input  wire logic [SUM_BITS+$clog2(MAX_WINDOW+1)-1:0] q_data,
    output logic                                       q_pop,
    input  wire logic                                  pop,
    output logic                                       empty,
    output logic signed [SAMPLE_BITS-1:0]              average
);

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W = $clog2(SUM_BITS);
    localparam int Q_W   = ((SAMPLE_BITS > SUM_BITS) ? SAMPLE_BITS : SUM_BITS) + 2;
    localparam logic signed [Q_W-1:0] SAT_HI = (Q_W'(1) <<< (SAMPLE_BITS - 1)) - Q_W'(1);
    localparam logic signed [Q_W-1:0] SAT_LO = -SAT_HI - Q_W'(1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [SUM_BITS-1:0]           quo_reg;
    logic [LEN_W-1:0]              rem_reg;
    logic [LEN_W-1:0]              div_reg;
    logic                          neg_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] average_reg;

    logic [SUM_BITS-1:0]           in_sum;
    logic [LEN_W-1:0]              in_div;
    logic [SUM_BITS-1:0]           in_mag;
    logic [LEN_W:0]                rem_sh;
    logic                          ge;
    logic                          last_step;
    logic                          out_free;
    logic                          deliver;
    logic signed [Q_W-1:0]         q_signed;
    logic signed [SAMPLE_BITS-1:0] q_sat;

    assign in_sum = q_data[SUM_BITS+LEN_W-1:LEN_W];
    assign in_div = q_data[LEN_W-1:0];
    assign in_mag = in_sum[SUM_BITS-1] ? -in_sum : in_sum;

    // one restoring step per cycle
    assign rem_sh    = {rem_reg, quo_reg[SUM_BITS-1]};
    assign ge        = rem_sh >= (LEN_W+1)'(div_reg);
    assign last_step = cnt_reg == CNT_W'(SUM_BITS - 1);

    // sign restore and clamp to the sample range
    assign q_signed = neg_reg ? -(Q_W'(quo_reg)) : Q_W'(quo_reg);
    always_comb
    begin
        priority if (q_signed > SAT_HI)
        begin
            q_sat = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (q_signed < SAT_LO)
        begin
            q_sat = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            q_sat = q_signed[SAMPLE_BITS-1:0];
        end
    end

    assign out_free = !out_valid_reg || pop;
    assign deliver  = (state_reg == S_DONE) && out_free;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign empty    = !out_valid_reg;
    assign average  = average_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (last_step)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_RUN)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // divider datapath and result register
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            quo_reg <= in_mag;
            rem_reg <= '0;
            div_reg <= in_div;
            neg_reg <= in_sum[SUM_BITS-1];
        end
        else if (state_reg == S_RUN)
        begin
            quo_reg <= {quo_reg[SUM_BITS-2:0], ge};
            rem_reg <= ge ? LEN_W'(rem_sh - (LEN_W+1)'(div_reg)) : rem_sh[LEN_W-1:0];
        end
        if (deliver)
        begin
            average_reg <= q_sat;
        end
    end

endmodule : mwa_back

`default_nettype wire

// ===== hdl/moving_window_average.sv =====
// moving window average, top level: front end, two entry queue, divider back end
// depends on mwa_pkg, mwa_front, mwa_fifo, mwa_back
// result path: sum stage, queue, 24 divide steps in the back end, output register
// the bit-serial divider in the back end takes a new beat only after the last one is delivered
// reset: asynchronous, clears pointers, fill count, sum and queues; window_length = 32
// the delay line is not cleared; entries are read only after being written
`default_nettype none

module moving_window_average
    import mwa_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [CFG_BITS-1:0]           cfg_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          start_of_record,
    input  wire logic                          pop,
    output logic                               empty,
    output logic signed [SAMPLE_BITS-1:0]      average
);

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int Q_BITS = SUM_BITS + LEN_W;

    logic              q_push;
    logic              q_full;
    logic [Q_BITS-1:0] q_wdata;
    logic              q_pop;
    logic              q_empty;
    logic [Q_BITS-1:0] q_rdata;

    // sample intake and running sum
    mwa_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .sample          (sample),
        .start_of_record (start_of_record),
        .q_push          (q_push),
        .q_full          (q_full),
        .q_data          (q_wdata)
    );

    // decoupling queue
    mwa_fifo #(
        .WIDTH (Q_BITS)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // division and result
    mwa_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .average (average)
    );

endmodule : moving_window_average

`default_nettype wire

// ===== hdl/mwa_checker.sv =====
// port-level checks for moving_window_average, bound to the top level
// depends on the top level's ports only
`default_nettype none

module mwa_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   push,
    input wire logic                   full,
    input wire logic                   pop,
    input wire logic                   empty,
    input wire logic [SAMPLE_BITS-1:0] average
);

    // beats accepted but not yet delivered: sum stage, queue, divider, output
    localparam logic [2:0] CAPACITY = 3'd5;

    logic [2:0] outstanding_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = push && !full;
    assign out_beat = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= 3'd0;
        end
        else if (in_beat && !out_beat)
        begin
            outstanding_reg <= outstanding_reg + 3'd1;
        end
        else if (out_beat && !in_beat)
        begin
            outstanding_reg <= outstanding_reg - 3'd1;
        end
    end

    // no result without a pending input beat
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 3'd0 |-> empty)
        else $error("result shown with no beat in flight");

    // in-flight beats never exceed the storage of the block
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= CAPACITY)
        else $error("more beats in flight than the block can hold");

    // backpressure only once the sum stage and queue are occupied
    a_full_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> outstanding_reg >= 3'd3)
        else $error("full raised with too few beats in flight");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(average))
        else $error("waiting result changed or vanished");

endmodule : mwa_checker

bind moving_window_average mwa_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mwa_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .average (average)
);

`default_nettype wire

// ===== tb/sv/moving_window_average_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the moving window average block
// depends on mwa_pkg and the moving_window_average rtl; compares each average with a predictor

module moving_window_average_tb;
    import mwa_pkg::*;

    localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
    localparam int DEPTH        = MAX_WINDOW_DEF;
    localparam int PTR_W        = $clog2(DEPTH);
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_BEATS = 800;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       first;
    } sample_beat_t;

    typedef enum {STYLE_FULL, STYLE_EXTREME, STYLE_HIGH, STYLE_LOW, STYLE_SMALL} sample_style_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_BITS-1:0]        cfg_data = '0;
    logic                       push = 1'b0;
    logic                       full;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       start_of_record = 1'b0;
    logic                       pop = 1'b0;
    logic                       empty;
    logic signed [SAMPLE_W-1:0] average;

    // stimulus and expectation stores
    sample_beat_t               pending_beats[$];
    logic signed [SAMPLE_W-1:0] expected_averages[$];

    // predictor state
    logic signed [SAMPLE_W-1:0] hist_line [DEPTH] = '{default: '0};
    logic [PTR_W-1:0]           hist_ptr = '0;
    logic signed [SUM_BITS-1:0] acc_sum = '0;
    int unsigned                record_count = 0;
    logic [CFG_BITS-1:0]        window_setting = WINDOW_RESET;

    int mismatch_count = 0;
    int cycle_count = 0;
    int burst_left = 1;
    int gap_left = 0;
    logic [31:0] stall_bits = '1;
    int stall_age = 0;

    moving_window_average #(
        .MAX_WINDOW  (DEPTH),
        .SAMPLE_BITS (SAMPLE_W)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .sample          (sample),
        .start_of_record (start_of_record),
        .pop             (pop),
        .empty           (empty),
        .average         (average)
    );

    always #10 clk = ~clk;

    // windowed mean of one new sample, updates the predictor state
    function automatic logic signed [SAMPLE_W-1:0] next_average(sample_beat_t b);
        int unsigned      span;
        int unsigned      divisor;
        logic [PTR_W-1:0] old_slot;
        longint           quotient;
        if (window_setting == 0)
            span = 1;
        else if (window_setting > DEPTH)
            span = DEPTH;
        else
            span = 32'(window_setting);
        if (b.first)
        begin
            acc_sum = '0;
            record_count = 0;
        end
        acc_sum = acc_sum + b.value;
        // drop the sample that leaves the window
        if (record_count >= span)
        begin
            old_slot = hist_ptr - span[PTR_W-1:0];
            acc_sum = acc_sum - hist_line[old_slot];
        end
        hist_line[hist_ptr] = b.value;
        hist_ptr = hist_ptr + 1'b1;
        divisor = (record_count + 1 < span) ? record_count + 1 : span;
        if (record_count < DEPTH)
            record_count++;
        // truncating divide, then clamp to the sample range
        quotient = longint'(acc_sum) / longint'(divisor);
        if (quotient > SAMPLE_MAX)
            quotient = longint'(SAMPLE_MAX);
        if (quotient < SAMPLE_MIN)
            quotient = longint'(SAMPLE_MIN);
        return quotient[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(sample_style_t style);
        case (style)
            STYLE_EXTREME: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            STYLE_HIGH:    return SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 15));
            STYLE_LOW:     return SAMPLE_MIN + SAMPLE_W'($urandom_range(0, 15));
            STYLE_SMALL:   return SAMPLE_W'($signed(5'($urandom)));
            default:       return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic add_beat(input logic signed [SAMPLE_W-1:0] value, input logic first);
        pending_beats.push_back('{value, first});
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || expected_averages.size() != 0)
            @(posedge clk);
    endtask

    // window register write, only called while nothing is in flight
    task automatic set_window(input logic [CFG_BITS-1:0] len);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        cfg_write <= 1'b0;
        window_setting = len;
    endtask

    task automatic log_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    // input driver: bursts of beats with random gaps, predicts on each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            sample <= '0;
            start_of_record <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_averages.push_back(next_average(pending_beats.pop_front()));
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                end
            end
            // hold a beat that was refused
            if (!(push && full))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    push <= 1'b1;
                    sample <= pending_beats[0].value;
                    start_of_record <= pending_beats[0].first;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // result side stall pattern: all ready, long stall or random bits, reloaded when stall_age runs out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (stall_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_bits = '1;
                    1:       stall_bits = '0;
                    default: stall_bits = $urandom;
                endcase
                stall_age = 64;
            end
            stall_age--;
            pop <= stall_bits[0];
            stall_bits = {stall_bits[0], stall_bits[31:1]};
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_averages.size() == 0)
                log_error($sformatf("unexpected average %0d", average));
            else if (average !== expected_averages[0])
                log_error($sformatf("average mismatch: expected %0d, got %0d",
                                    expected_averages[0], average));
            if (expected_averages.size() != 0)
                void'(expected_averages.pop_front());
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int                  random_total;
        int                  phase_len;
        int                  span;
        logic [CFG_BITS-1:0] len;
        logic                fresh;
        logic                first;
        logic                flip;
        sample_style_t       style;
        random_total = 0;
        style = STYLE_FULL;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset window: extremes and truncation toward zero
        add_beat(SAMPLE_MAX, 1'b1);
        add_beat(SAMPLE_MAX, 1'b0);
        add_beat(SAMPLE_MIN, 1'b1);
        add_beat(SAMPLE_MIN, 1'b0);
        add_beat(SAMPLE_W'(-3), 1'b1);
        add_beat(SAMPLE_W'(0), 1'b0);
        add_beat(SAMPLE_W'(5), 1'b1);
        add_beat(SAMPLE_W'(-8), 1'b0);
        add_beat(SAMPLE_W'(0), 1'b1);
        wait_idle();

        // zero length acts as one, changed inside a record
        set_window('0);
        add_beat(SAMPLE_W'(7), 1'b0);
        add_beat(SAMPLE_W'(-7), 1'b0);
        add_beat(SAMPLE_MIN, 1'b0);
        wait_idle();

        // short window with the oldest sample dropped, then a full window of max
        set_window(9'd3);
        add_beat(SAMPLE_W'(100), 1'b1);
        add_beat(SAMPLE_W'(200), 1'b0);
        add_beat(SAMPLE_W'(300), 1'b0);
        add_beat(SAMPLE_W'(400), 1'b0);
        add_beat(SAMPLE_MAX, 1'b1);
        add_beat(SAMPLE_MAX, 1'b0);
        add_beat(SAMPLE_MAX, 1'b0);
        wait_idle();

        // shrink inside the record: quotient saturates high
        set_window(9'd1);
        add_beat(SAMPLE_MAX, 1'b0);
        wait_idle();
        set_window(9'd3);
        add_beat(SAMPLE_MIN, 1'b1);
        add_beat(SAMPLE_MIN, 1'b0);
        add_beat(SAMPLE_MIN, 1'b0);
        wait_idle();
        // and saturates low
        set_window(9'd1);
        add_beat(SAMPLE_MIN, 1'b0);
        wait_idle();

        // grow the window inside a record so the sum wraps
        flip = 1'($urandom_range(0, 1));
        span = $urandom_range(140, 200);
        set_window(9'd1);
        for (int i = 0; i < span; i++)
            add_beat(flip ? SAMPLE_MAX : SAMPLE_MIN, i == 0);
        wait_idle();
        set_window(span[CFG_BITS-1:0]);
        for (int i = 0; i < span; i++)
            add_beat(flip ? SAMPLE_MIN : SAMPLE_MAX, 1'b0);
        random_total = 2 * span;
        wait_idle();

        // random phases, each with its own window setting
        while (random_total < RANDOM_BEATS)
        begin
            case ($urandom_range(0, 9))
                0:       len = '0;
                1:       len = 9'd1;
                2:       len = 9'd2;
                3:       len = CFG_BITS'(DEPTH);
                4:       len = CFG_BITS'(DEPTH + 1);
                5:       len = '1;
                6, 7:    len = CFG_BITS'($urandom_range(1, 16));
                default: len = CFG_BITS'($urandom_range(1, DEPTH));
            endcase
            set_window(len);
            fresh = ($urandom_range(0, 2) == 0);
            phase_len = $urandom_range(8, 60);
            for (int i = 0; i < phase_len; i++)
            begin
                first = (i == 0 && fresh) || ($urandom_range(0, 199) == 0);
                if (first)
                    style = sample_style_t'($urandom_range(0, 4));
                add_beat(pick_sample(style), first);
            end
            random_total += phase_len;
            wait_idle();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
